// ----- rtl/core/prrs_pkg.sv -----
`timescale 1ns / 1ps

package prrs_pkg;

    // table depth and derived widths
    localparam int MAX_TASKS = 16;
    localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);

    localparam int ID_W    = 8;
    localparam int PRIO_W  = 4;
    localparam int BURST_W = 16;
    localparam int QUANT_W = 8;

    localparam logic [QUANT_W-1:0] QUANTUM_RESET = 8'd10;

    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [MAX_TASKS-1:0] t_mask;

    // sequencer codes
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_SEEK   = 3'd3;
    localparam logic [2:0] ST_SERVE  = 3'd4;

    // input opcodes
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_SLICE = 1'b1;

    // circular successor of a table slot
    function automatic t_idx next_idx(input t_idx i);
        if (i == t_idx'(MAX_TASKS - 1)) begin
            return '0;
        end else begin
            return i + t_idx'(1);
        end
    endfunction

endpackage

// ----- rtl/core/priority_round_robin_scheduler_core.sv -----
`timescale 1ns / 1ps

// Priority scheduler with round robin among tasks of equal top priority.
// Command channel: present i_opcode and task fields with start high; the
// beat is taken at the edge where start is high and busy is low.
//   Add (opcode 0): stored, no result. Ignored once a task has finished or a
//   round robin group is active. A full table gives a result with
//   o_add_rejected set on the next cycle.
//   Slice request (opcode 1): one result beat, marked by o_strobe for one
//   cycle. A fresh selection scans the table through one priority
//   comparator, one slot per cycle; when nothing is left the beat reports
//   all done, and when a group forms a round robin search follows, one
//   slot a cycle. Later slices of a running group take only the search and
//   the serve step. Tables sit in small RAMs with registered reads; the
//   serve step reuses one compare/subtract.
// busy stays high from a slice request until its result beat.
// Quantum is written through i_quantum_we/i_quantum while idle; the user
// must keep to this, the block does not enforce it. 0 acts as 1.
// Reset (synchronous, active low) empties the table, clears the done mask
// and group state and sets the quantum to 10. Table contents are not cleared.
// The receiver cannot stall: each result is valid for its strobe cycle only.
module priority_round_robin_scheduler_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_opcode,
    input  logic [prrs_pkg::ID_W-1:0]     i_task_id,
    input  logic [prrs_pkg::PRIO_W-1:0]   i_task_priority,
    input  logic [prrs_pkg::BURST_W-1:0]  i_task_burst,
    input  logic                          i_quantum_we,
    input  logic [prrs_pkg::QUANT_W-1:0]  i_quantum,
    output logic                          o_strobe,
    output logic [prrs_pkg::ID_W-1:0]     o_slice_task,
    output logic [prrs_pkg::BURST_W-1:0]  o_slice_length,
    output logic                          o_task_finished,
    output logic                          o_all_done,
    output logic                          o_add_rejected
);

    // ---------------------------------------------------------------
    // table RAMs
    // ---------------------------------------------------------------
    logic [prrs_pkg::PRIO_W-1:0]  prio_mem  [prrs_pkg::MAX_TASKS];
    logic [prrs_pkg::BURST_W-1:0] burst_mem [prrs_pkg::MAX_TASKS];
    logic [prrs_pkg::ID_W-1:0]    id_mem    [prrs_pkg::MAX_TASKS];

    logic [prrs_pkg::PRIO_W-1:0]  r_prio_q;
    logic [prrs_pkg::BURST_W-1:0] r_burst_q;
    logic [prrs_pkg::ID_W-1:0]    r_id_q;

    prrs_pkg::t_idx               rd_addr;
    logic                         tab_we;
    logic                         burst_we;
    prrs_pkg::t_idx               burst_waddr;
    logic [prrs_pkg::BURST_W-1:0] burst_wdata;

    // ---------------------------------------------------------------
    // control and scheduling state
    // ---------------------------------------------------------------
    logic [2:0]                   r_state, n_state;
    prrs_pkg::t_cnt               r_count, n_count;
    prrs_pkg::t_mask              r_done_mask, n_done_mask;
    prrs_pkg::t_mask              r_gmask, n_gmask;
    logic                         r_group_active, n_group_active;
    prrs_pkg::t_idx               r_rr, n_rr;
    logic [prrs_pkg::QUANT_W-1:0] r_quantum, n_quantum;

    // scan pipeline: read issued at r_ptr, compared in the next cycle at r_pidx
    prrs_pkg::t_cnt               r_ptr, n_ptr;
    logic                         r_pv, n_pv;
    prrs_pkg::t_idx               r_pidx, n_pidx;
    logic                         r_found, n_found;
    logic                         r_multi, n_multi;
    logic [prrs_pkg::PRIO_W-1:0]  r_best, n_best;
    prrs_pkg::t_idx               r_first, n_first;

    // round robin search and served slot
    prrs_pkg::t_idx               r_k, n_k;
    prrs_pkg::t_idx               r_sel, n_sel;
    logic                         r_is_group, n_is_group;

    // result beat
    logic                         r_strobe, n_strobe;
    logic [prrs_pkg::ID_W-1:0]    r_slice_task, n_slice_task;
    logic [prrs_pkg::BURST_W-1:0] r_slice_length, n_slice_length;
    logic                         r_task_finished, n_task_finished;
    logic                         r_all_done, n_all_done;
    logic                         r_add_rejected, n_add_rejected;

    logic [prrs_pkg::BURST_W-1:0] lim;
    logic [prrs_pkg::QUANT_W-1:0] q_eff;
    prrs_pkg::t_mask              gmask_after;

    assign busy = (r_state != prrs_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            prio_mem[r_count[prrs_pkg::IDX_W-1:0]] <= i_task_priority;
            id_mem[r_count[prrs_pkg::IDX_W-1:0]]   <= i_task_id;
        end
        if (burst_we) begin
            burst_mem[burst_waddr] <= burst_wdata;
        end
        r_prio_q  <= prio_mem[rd_addr];
        r_burst_q <= burst_mem[rd_addr];
        r_id_q    <= id_mem[rd_addr];
    end

    always_comb begin
        n_state         = r_state;
        n_count         = r_count;
        n_done_mask     = r_done_mask;
        n_gmask         = r_gmask;
        n_group_active  = r_group_active;
        n_rr            = r_rr;
        n_quantum       = r_quantum;
        n_ptr           = r_ptr;
        n_pv            = r_pv;
        n_pidx          = r_pidx;
        n_found         = r_found;
        n_multi         = r_multi;
        n_best          = r_best;
        n_first         = r_first;
        n_k             = r_k;
        n_sel           = r_sel;
        n_is_group      = r_is_group;
        n_strobe        = 1'b0;
        n_slice_task    = r_slice_task;
        n_slice_length  = r_slice_length;
        n_task_finished = r_task_finished;
        n_all_done      = r_all_done;
        n_add_rejected  = r_add_rejected;

        rd_addr     = r_sel;
        tab_we      = 1'b0;
        burst_we    = 1'b0;
        burst_waddr = r_sel;
        burst_wdata = '0;
        gmask_after = r_gmask;

        q_eff = (r_quantum == '0) ? prrs_pkg::QUANT_W'(1) : r_quantum;
        lim   = r_is_group ? {{(prrs_pkg::BURST_W - prrs_pkg::QUANT_W){1'b0}}, q_eff}
                           : {prrs_pkg::BURST_W{1'b1}};

        if (i_quantum_we) begin
            n_quantum = i_quantum;
        end

        case (r_state)
            prrs_pkg::ST_IDLE: begin
                if (start) begin
                    if (i_opcode == prrs_pkg::OP_ADD) begin
                        if (r_done_mask == '0 && !r_group_active) begin
                            if (r_count >= prrs_pkg::CNT_W'(prrs_pkg::MAX_TASKS)) begin
                                n_strobe        = 1'b1;
                                n_slice_task    = '0;
                                n_slice_length  = '0;
                                n_task_finished = 1'b0;
                                n_all_done      = 1'b0;
                                n_add_rejected  = 1'b1;
                            end else begin
                                tab_we      = 1'b1;
                                burst_we    = 1'b1;
                                burst_waddr = r_count[prrs_pkg::IDX_W-1:0];
                                burst_wdata = i_task_burst;
                                n_count     = r_count + prrs_pkg::CNT_W'(1);
                            end
                        end
                    end else if (r_group_active && r_gmask != '0) begin
                        n_k     = r_rr;
                        n_state = prrs_pkg::ST_SEEK;
                    end else begin
                        n_group_active = 1'b0;
                        n_ptr          = '0;
                        n_pv           = 1'b0;
                        n_found        = 1'b0;
                        n_multi        = 1'b0;
                        n_gmask        = '0;
                        n_state        = prrs_pkg::ST_SCAN;
                    end
                end
            end

            prrs_pkg::ST_SCAN: begin
                rd_addr = r_ptr[prrs_pkg::IDX_W-1:0];
                if (r_pv && !r_done_mask[r_pidx]) begin
                    if (!r_found || r_prio_q > r_best) begin
                        n_best  = r_prio_q;
                        n_found = 1'b1;
                        n_first = r_pidx;
                        n_multi = 1'b0;
                        n_gmask = prrs_pkg::t_mask'(1) << r_pidx;
                    end else if (r_prio_q == r_best) begin
                        n_multi = 1'b1;
                        n_gmask = r_gmask | (prrs_pkg::t_mask'(1) << r_pidx);
                    end
                end
                if (r_ptr < r_count) begin
                    n_pv   = 1'b1;
                    n_pidx = r_ptr[prrs_pkg::IDX_W-1:0];
                    n_ptr  = r_ptr + prrs_pkg::CNT_W'(1);
                end else begin
                    n_pv    = 1'b0;
                    n_state = prrs_pkg::ST_DECIDE;
                end
            end

            prrs_pkg::ST_DECIDE: begin
                rd_addr = r_first;
                if (!r_found) begin
                    n_strobe        = 1'b1;
                    n_slice_task    = '0;
                    n_slice_length  = '0;
                    n_task_finished = 1'b0;
                    n_all_done      = 1'b1;
                    n_add_rejected  = 1'b0;
                    n_state         = prrs_pkg::ST_IDLE;
                end else if (!r_multi) begin
                    n_sel      = r_first;
                    n_is_group = 1'b0;
                    n_state    = prrs_pkg::ST_SERVE;
                end else begin
                    n_group_active = 1'b1;
                    n_rr           = '0;
                    n_k            = '0;
                    n_state        = prrs_pkg::ST_SEEK;
                end
            end

            prrs_pkg::ST_SEEK: begin
                rd_addr = r_k;
                if (r_gmask[r_k]) begin
                    n_sel      = r_k;
                    n_is_group = 1'b1;
                    n_state    = prrs_pkg::ST_SERVE;
                end else begin
                    n_k = prrs_pkg::next_idx(r_k);
                end
            end

            prrs_pkg::ST_SERVE: begin
                burst_we     = 1'b1;
                burst_waddr  = r_sel;
                n_strobe     = 1'b1;
                n_slice_task = r_id_q;
                n_all_done   = 1'b0;
                n_add_rejected = 1'b0;
                if (r_burst_q <= lim) begin
                    n_slice_length  = r_burst_q;
                    n_task_finished = 1'b1;
                    burst_wdata     = '0;
                    n_done_mask     = r_done_mask | (prrs_pkg::t_mask'(1) << r_sel);
                    gmask_after     = r_gmask & ~(prrs_pkg::t_mask'(1) << r_sel);
                end else begin
                    n_slice_length  = lim;
                    n_task_finished = 1'b0;
                    burst_wdata     = r_burst_q - lim;
                end
                if (r_is_group) begin
                    n_gmask = gmask_after;
                    n_rr    = prrs_pkg::next_idx(r_sel);
                    if (gmask_after == '0) begin
                        n_group_active = 1'b0;
                    end
                end else begin
                    n_gmask = '0;
                end
                n_state = prrs_pkg::ST_IDLE;
            end

            default: begin
                n_state = prrs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= prrs_pkg::ST_IDLE;
            r_count        <= '0;
            r_done_mask    <= '0;
            r_gmask        <= '0;
            r_group_active <= 1'b0;
            r_rr           <= '0;
            r_quantum      <= prrs_pkg::QUANTUM_RESET;
            r_ptr          <= '0;
            r_pv           <= 1'b0;
            r_found        <= 1'b0;
            r_multi        <= 1'b0;
            r_is_group     <= 1'b0;
            r_strobe       <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_count        <= n_count;
            r_done_mask    <= n_done_mask;
            r_gmask        <= n_gmask;
            r_group_active <= n_group_active;
            r_rr           <= n_rr;
            r_quantum      <= n_quantum;
            r_ptr          <= n_ptr;
            r_pv           <= n_pv;
            r_found        <= n_found;
            r_multi        <= n_multi;
            r_is_group     <= n_is_group;
            r_strobe       <= n_strobe;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_pidx          <= n_pidx;
        r_best          <= n_best;
        r_first         <= n_first;
        r_k             <= n_k;
        r_sel           <= n_sel;
        r_slice_task    <= n_slice_task;
        r_slice_length  <= n_slice_length;
        r_task_finished <= n_task_finished;
        r_all_done      <= n_all_done;
        r_add_rejected  <= n_add_rejected;
    end

    assign o_strobe        = r_strobe;
    assign o_slice_task    = r_slice_task;
    assign o_slice_length  = r_slice_length;
    assign o_task_finished = r_task_finished;
    assign o_all_done      = r_all_done;
    assign o_add_rejected  = r_add_rejected;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    // a live group always has members, none of them finished
    a_group_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_group_active |-> (r_gmask != '0) && ((r_gmask & r_done_mask) == '0))
        else $error("group state inconsistent");

    // a result beat carries at most one of the three flags
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $onehot0({o_task_finished, o_all_done, o_add_rejected}))
        else $error("result flags collide");

    // every slice request ends in exactly the beat that drops busy
    a_busy_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> o_strobe)
        else $error("request finished without a result beat");

endmodule
